/* rtl/core/sseq_pkg.sv */
// ----------------------------------------------------------------------------
// sseq_pkg
// Shared types and constants for the sorted sequence merge block.
// ----------------------------------------------------------------------------
package sseq_pkg;

    localparam int DATA_W = 32;
    localparam int CMD_W  = 2;

    // Bit positions inside the result tuser
    localparam int USER_SEC_BIT = 0;
    localparam int USER_OVF_BIT = 1;
    localparam int OUT_USER_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_FIRST  = 2'd0,
        CMD_LOAD_SECOND = 2'd1,
        CMD_MERGE       = 2'd2,
        CMD_CLEAR       = 2'd3
    } cmd_t;

    typedef logic signed [DATA_W-1:0] data_t;

endpackage

/* rtl/core/sorted_sequence_merge.sv */
// ----------------------------------------------------------------------------
// sorted_sequence_merge
// Two list buffers of signed values with a two-way merge that streams the
// combined run out of the buffer read ports.
// ----------------------------------------------------------------------------
// Load and clear: clear gives no result; a load result is on m_* in the cycle
//   after the item is accepted, and loads go back to back while m_tready is high.
// Merge: heads pass the buffer read register, then the output register;
//   results follow one per cycle while m_tready is high, paced by the single
//   read port of each buffer. s_tready is low while the merge runs.
// Reset clears both counts, the sequencer and the output valid; buffer
//   contents are left as they are and only entries below the counts are used.
// ----------------------------------------------------------------------------
module sorted_sequence_merge #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic signed [sseq_pkg::DATA_W-1:0] s_tdata,  // [31:0] value
    input  logic [sseq_pkg::CMD_W-1:0]        s_tuser,  // [1:0] cmd
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic signed [sseq_pkg::DATA_W-1:0] m_tdata,  // [31:0] merged_value
    output logic [sseq_pkg::OUT_USER_W-1:0]   m_tuser,  // [0] from_second, [1] overflow
    output logic                              m_tlast
);
    import sseq_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] first_cnt_reg, first_cnt_next;
    logic [CW-1:0] second_cnt_reg, second_cnt_next;
    logic [CW-1:0] first_idx_reg, first_idx_next;
    logic [CW-1:0] second_idx_reg, second_idx_next;
    logic          out_valid_reg, out_valid_next;
    data_t         out_data_reg, out_data_next;
    logic          out_sec_reg, out_sec_next;
    logic          out_last_reg, out_last_next;
    logic          out_ovf_reg, out_ovf_next;

    logic          out_free;
    logic          in_fire;
    cmd_t          cmd;
    logic          first_full, second_full;
    logic          first_we, second_we;
    logic          first_has, second_has;
    logic          take_first;
    logic          run_last;
    logic [CW-1:0] first_idx_inc, second_idx_inc;
    data_t         first_head, second_head;

    sseq_list_mem #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_first_mem (
        .aclk    (aclk),
        .wr_en   (first_we),
        .wr_addr (first_cnt_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (first_idx_next[AW-1:0]),
        .rd_data (first_head)
    );

    sseq_list_mem #(
        .DEPTH (LIST_DEPTH),
        .AW    (AW)
    ) u_second_mem (
        .aclk    (aclk),
        .wr_en   (second_we),
        .wr_addr (second_cnt_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (second_idx_next[AW-1:0]),
        .rd_data (second_head)
    );

    assign out_free    = !out_valid_reg || m_tready;
    assign s_tready    = (state_reg == ST_IDLE) && out_free;
    assign in_fire     = s_tvalid && s_tready;
    assign cmd         = cmd_t'(s_tuser);
    assign first_full  = (first_cnt_reg == CW'(LIST_DEPTH));
    assign second_full = (second_cnt_reg == CW'(LIST_DEPTH));

    assign first_has      = (first_idx_reg != first_cnt_reg);
    assign second_has     = (second_idx_reg != second_cnt_reg);
    assign first_idx_inc  = first_idx_reg + CW'(1);
    assign second_idx_inc = second_idx_reg + CW'(1);
    // tie goes to the second list
    assign take_first = first_has && (!second_has || (first_head < second_head));
    assign run_last   = take_first ? ((first_idx_inc == first_cnt_reg) && !second_has)
                                   : (!first_has && (second_idx_inc == second_cnt_reg));

    always_comb begin
        state_next      = state_reg;
        first_cnt_next  = first_cnt_reg;
        second_cnt_next = second_cnt_reg;
        first_idx_next  = first_idx_reg;
        second_idx_next = second_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_sec_next    = out_sec_reg;
        out_last_next   = out_last_reg;
        out_ovf_next    = out_ovf_reg;
        first_we        = 1'b0;
        second_we       = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    case (cmd)
                        CMD_LOAD_FIRST: begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            out_sec_next   = 1'b0;
                            out_last_next  = 1'b0;
                            out_ovf_next   = first_full;
                            if (!first_full) begin
                                first_we       = 1'b1;
                                first_cnt_next = first_cnt_reg + CW'(1);
                            end
                        end
                        CMD_LOAD_SECOND: begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            out_sec_next   = 1'b0;
                            out_last_next  = 1'b0;
                            out_ovf_next   = second_full;
                            if (!second_full) begin
                                second_we       = 1'b1;
                                second_cnt_next = second_cnt_reg + CW'(1);
                            end
                        end
                        CMD_MERGE: begin
                            // point both read ports at the heads
                            first_idx_next  = '0;
                            second_idx_next = '0;
                            if ((first_cnt_reg != '0) || (second_cnt_reg != '0)) begin
                                state_next = ST_MERGE;
                            end
                        end
                        CMD_CLEAR: begin
                            first_cnt_next  = '0;
                            second_cnt_next = '0;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MERGE: begin
                // hold indexes while the output slot is occupied
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = take_first ? first_head : second_head;
                    out_sec_next   = !take_first;
                    out_last_next  = run_last;
                    out_ovf_next   = 1'b0;
                    if (take_first) begin
                        first_idx_next = first_idx_inc;
                    end else begin
                        second_idx_next = second_idx_inc;
                    end
                    if (run_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            first_idx_reg  <= '0;
            second_idx_reg <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            first_idx_reg  <= first_idx_next;
            second_idx_reg <= second_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_sec_reg  <= out_sec_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid                = out_valid_reg;
    assign m_tdata                 = out_data_reg;
    assign m_tuser[USER_SEC_BIT]   = out_sec_reg;
    assign m_tuser[USER_OVF_BIT]   = out_ovf_reg;
    assign m_tlast                 = out_last_reg;

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (first_cnt_reg <= CW'(LIST_DEPTH)) && (second_cnt_reg <= CW'(LIST_DEPTH)))
        else $error("list count beyond depth");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE) |->
        (first_idx_reg <= first_cnt_reg) && (second_idx_reg <= second_cnt_reg))
        else $error("merge index beyond count");

    a_merge_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MERGE) |-> (first_has || second_has))
        else $error("merge active with both lists drained");

    a_ovf_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[USER_OVF_BIT]) |-> (!m_tlast && !m_tuser[USER_SEC_BIT]))
        else $error("overflow result carries merge flags");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_MERGE) && out_free && run_last) |=> (state_reg == ST_IDLE))
        else $error("merge did not end after last item");

endmodule

/* rtl/core/sseq_list_mem.sv */
// ----------------------------------------------------------------------------
// sseq_list_mem
// One list buffer: single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module sseq_list_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  sseq_pkg::data_t    wr_data,
    input  logic [AW-1:0]      rd_addr,
    output sseq_pkg::data_t    rd_data
);
    import sseq_pkg::*;

    data_t mem [DEPTH];
    data_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
